@@ hw/rtl/rnc14_pkg.sv @@
// Shared types, controller codes and event expansion for the RPN/NRPN/14-bit CC assembler.
package rnc14_pkg;

  localparam int PORT_BITS_DEF = 2;
  localparam int MAX_EV        = 4;

  typedef logic [1:0] kind_t;
  localparam kind_t K_NONE  = 2'd0;  // empty slot; also the plain-CC event kind
  localparam kind_t K_PLAIN = 2'd0;
  localparam kind_t K_RPN   = 2'd1;
  localparam kind_t K_NRPN  = 2'd2;
  localparam kind_t K_CC14  = 2'd3;

  localparam logic [6:0] CC_RPN_MSB   = 7'h65;
  localparam logic [6:0] CC_RPN_LSB   = 7'h64;
  localparam logic [6:0] CC_NRPN_MSB  = 7'h63;
  localparam logic [6:0] CC_NRPN_LSB  = 7'h62;
  localparam logic [6:0] CC_DATA_MSB  = 7'h06;
  localparam logic [6:0] CC_DATA_LSB  = 7'h26;
  localparam logic [6:0] CC14_OFS     = 7'h20;
  localparam logic [6:0] CC14_LSB_END = 7'h40;

  // one held 7-bit part with its present flag
  typedef struct packed {
    logic       pres;
    logic [6:0] val;
  } part_t;

  typedef struct packed {
    kind_t       kind;
    part_t       ph;
    part_t       pl;
    part_t       dh;
    part_t       dl;
    logic [31:0] tstamp;
  } slot_t;

  typedef struct packed {
    logic        mode;
    logic [6:0]  ctl;
    logic [6:0]  val;
    logic [31:0] tstamp;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] param;
    logic [13:0] value;
  } ev_t;

  typedef struct packed {
    logic [2:0]              cnt;
    ev_t [MAX_EV-1:0]        ev;
  } ev_list_t;

  function automatic logic [13:0] join14(part_t hi, part_t lo);
    logic [13:0] r;
    r = '0;
    if (lo.pres) begin
      r = {(hi.pres ? hi.val : 7'd0), lo.val};
    end else if (hi.pres) begin
      r = {7'd0, hi.val};
    end
    return r;
  endfunction

  // Turn an emitted slot into its event list: one assembled event when
  // complete, else each held part as a plain CC, packed to the front.
  function automatic ev_list_t expand(slot_t s);
    ev_t        cand [MAX_EV];
    logic [3:0] keep;
    logic [2:0] n;
    logic       p_any;
    logic       d14;
    ev_list_t   r;
    r     = '0;
    keep  = '0;
    n     = '0;
    p_any = s.ph.pres | s.pl.pres;
    d14   = s.dh.pres & s.dl.pres;
    for (int i = 0; i < MAX_EV; i++) begin
      cand[i] = '0;
    end
    if (s.kind == K_NONE) begin
      keep = '0;
    end else if (p_any && d14) begin
      keep[0]       = 1'b1;
      cand[0].kind  = s.kind;
      cand[0].param = (s.kind == K_CC14) ? {7'd0, s.ph.val} : join14(s.ph, s.pl);
      cand[0].value = join14(s.dh, s.dl);
    end else if (s.kind == K_CC14) begin
      keep[0]       = s.dh.pres;
      cand[0].kind  = K_PLAIN;
      cand[0].param = {7'd0, s.ph.val};
      cand[0].value = {7'd0, s.dh.val};
      keep[1]       = s.dl.pres;
      cand[1].kind  = K_PLAIN;
      cand[1].param = {7'd0, s.pl.val};
      cand[1].value = {7'd0, s.dl.val};
    end else begin
      keep          = {s.dl.pres, s.dh.pres, s.pl.pres, s.ph.pres};
      cand[0].kind  = K_PLAIN;
      cand[0].param = {7'd0, (s.kind == K_RPN) ? CC_RPN_MSB : CC_NRPN_MSB};
      cand[0].value = {7'd0, s.ph.val};
      cand[1].kind  = K_PLAIN;
      cand[1].param = {7'd0, (s.kind == K_RPN) ? CC_RPN_LSB : CC_NRPN_LSB};
      cand[1].value = {7'd0, s.pl.val};
      cand[2].kind  = K_PLAIN;
      cand[2].param = {7'd0, CC_DATA_MSB};
      cand[2].value = {7'd0, s.dh.val};
      cand[3].kind  = K_PLAIN;
      cand[3].param = {7'd0, CC_DATA_LSB};
      cand[3].value = {7'd0, s.dl.val};
    end
    for (int i = 0; i < MAX_EV; i++) begin
      if (keep[i]) begin
        r.ev[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    r.cnt = n;
    return r;
  endfunction

endpackage

@@ hw/rtl/rnc14_slot_ram.sv @@
// Slot table: one synchronous RAM, one write and one registered read port.
module rnc14_slot_ram
  import rnc14_pkg::*;
#(
  parameter int ADDR_W = PORT_BITS_DEF + 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_t             rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_t             wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/rnc14_upd.sv @@
// Slot update: next slot contents, emitted snapshot and absorb flag for one request.
module rnc14_upd
  import rnc14_pkg::*;
(
  input  req_t  req,
  input  slot_t cur,
  output slot_t nxt,
  output slot_t snap,
  output logic  acc
);

  slot_t empty_s;
  slot_t base;
  part_t np;
  kind_t pkind;
  logic  is_par;
  logic  is_hi;
  logic  is_data;
  logic  cc_hi;
  logic  cc_lo;
  logic  any;
  logic  held;
  logic  brk;

  assign empty_s = '0;
  assign np      = '{pres: 1'b1, val: req.val};
  assign any     = cur.ph.pres | cur.pl.pres | cur.dh.pres | cur.dl.pres;
  assign is_par  = (req.ctl == CC_RPN_MSB) || (req.ctl == CC_RPN_LSB) ||
                   (req.ctl == CC_NRPN_MSB) || (req.ctl == CC_NRPN_LSB);
  assign pkind   = ((req.ctl == CC_RPN_MSB) || (req.ctl == CC_RPN_LSB)) ? K_RPN : K_NRPN;
  assign is_hi   = (req.ctl == CC_RPN_MSB) || (req.ctl == CC_NRPN_MSB) ||
                   (req.ctl == CC_DATA_MSB);
  assign is_data = (req.ctl == CC_DATA_MSB) || (req.ctl == CC_DATA_LSB);
  assign cc_hi   = (req.ctl != 7'd0) && (req.ctl < CC14_OFS);
  assign cc_lo   = (req.ctl > CC14_OFS) && (req.ctl < CC14_LSB_END);

  always_comb begin
    nxt  = cur;
    snap = empty_s;
    acc  = 1'b0;
    base = cur;
    held = 1'b0;
    brk  = 1'b0;
    priority if (req.mode) begin
      snap = cur;
      nxt  = empty_s;
    end else if (is_par) begin
      held = is_hi ? cur.ph.pres : cur.pl.pres;
      brk  = held || (any && (cur.kind != pkind));
      if (brk) begin
        snap = cur;
        base = empty_s;
      end
      if (base.kind == K_NONE) begin
        base.kind   = pkind;
        base.tstamp = req.tstamp;
      end
      if (is_hi) base.ph = np;
      else       base.pl = np;
      nxt = base;
      acc = 1'b1;
    end else if (is_data) begin
      held = is_hi ? cur.dh.pres : cur.dl.pres;
      if (cur.kind == K_NONE) begin
        nxt = cur;
      end else if (held || ((cur.kind != K_RPN) && (cur.kind != K_NRPN))) begin
        snap = cur;
        nxt  = empty_s;
      end else begin
        if (is_hi) base.dh = np;
        else       base.dl = np;
        acc = 1'b1;
        if ((base.ph.pres | base.pl.pres) && base.dh.pres && base.dl.pres) begin
          snap = base;
          nxt  = empty_s;
        end else begin
          nxt = base;
        end
      end
    end else if (cc_hi || cc_lo) begin
      if (cc_hi) begin
        brk = cur.ph.pres || cur.dh.pres || (any && (cur.kind != K_CC14)) ||
              ((cur.kind == K_CC14) && (cur.pl.val != 7'(req.ctl + CC14_OFS)));
      end else begin
        brk = cur.pl.pres || cur.dl.pres || (any && (cur.kind != K_CC14)) ||
              ((cur.kind == K_CC14) && (cur.ph.val != 7'(req.ctl - CC14_OFS)));
      end
      if (brk) begin
        snap = cur;
        base = empty_s;
      end
      if (base.kind == K_NONE) begin
        base.kind   = K_CC14;
        base.tstamp = req.tstamp;
      end
      if (cc_hi) begin
        base.ph = '{pres: 1'b1, val: req.ctl};
        base.dh = np;
      end else begin
        base.pl = '{pres: 1'b1, val: req.ctl};
        base.dl = np;
      end
      acc = 1'b1;
      if ((base.ph.pres | base.pl.pres) && base.dh.pres && base.dl.pres) begin
        snap = base;
        nxt  = empty_s;
      end else begin
        nxt = base;
      end
    end else begin
      nxt = cur;
    end
  end

endmodule

@@ hw/rtl/rnc14_emit.sv @@
// Result queue: expands an emitted slot into up to four results, one per cycle unless out_stall holds them.
module rnc14_emit
  import rnc14_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ld,
  input  slot_t       ld_snap,
  input  logic        ld_acc,
  input  logic [1:0]  ld_port,
  input  logic [3:0]  ld_channel,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_event,
  output logic        out_accepted,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_port,
  output logic [3:0]  out_channel,
  output logic [13:0] out_param,
  output logic [13:0] out_value,
  output logic [31:0] out_time,
  output logic        out_last
);

  ev_t [MAX_EV-1:0] ev_r;
  logic [2:0]       cnt_r;
  logic             has_r;
  logic             acc_r;
  logic [1:0]       port_r;
  logic [3:0]       chan_r;
  logic [31:0]      time_r;
  ev_list_t         lst;
  logic             take;
  logic             empty_lst;

  assign lst       = expand(ld_snap);
  assign empty_lst = (lst.cnt == 3'd0);
  assign take      = out_valid && !out_stall;
  assign free      = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ld) begin
      cnt_r <= empty_lst ? 3'd1 : lst.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ev_r   <= empty_lst ? '0 : lst.ev;
      has_r  <= !empty_lst;
      acc_r  <= ld_acc;
      port_r <= empty_lst ? 2'd0 : ld_port;
      chan_r <= empty_lst ? 4'd0 : ld_channel;
      time_r <= empty_lst ? 32'd0 : ld_snap.tstamp;
    end else if (take) begin
      for (int i = 0; i < MAX_EV - 1; i++) begin
        ev_r[i] <= ev_r[i+1];
      end
    end
  end

  assign out_valid     = (cnt_r != 3'd0);
  assign out_last      = (cnt_r == 3'd1);
  assign out_has_event = has_r;
  assign out_accepted  = acc_r;
  assign out_kind      = ev_r[0].kind;
  assign out_port      = port_r;
  assign out_channel   = chan_r;
  assign out_param     = ev_r[0].param;
  assign out_value     = ev_r[0].value;
  assign out_time      = time_r;

  a_ld_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> free)
    else $error("result queue loaded while results still pending");

  a_drop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_last && !out_stall))
    else $error("result queue emptied before last result was taken");

endmodule

@@ hw/rtl/midi_rpn_nrpn_cc14_assembler.sv @@
// Top level: MIDI RPN/NRPN/14-bit CC assembler with slot RAM, update logic and result queue.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  in_     | in  | in_valid/in_stall  | mode, port, channel, controller, cc_value, time
//  out_    | out | out_valid/out_stall| has_event, accepted, kind, port, channel,
//          |     |                    | param, value, time, last
//
// Flow: a request is accepted in IDLE and its slot is read from RAM at that edge; in
//   EXEC the updated slot is written back once the result queue is free.
//   Its 1 to 4 results then leave the queue one per cycle while out_stall is low, and
//   the next request can already do its lookup meanwhile.
// Reset: a clearing pass writes every slot empty, all 16 << PORT_BITS of them (64 by
//   default), with in_stall high.
// Stalls: out_stall holds the queue; a looked-up request waits for the queue before it
//   commits, and in_stall stays high meanwhile.
module midi_rpn_nrpn_cc14_assembler
  import rnc14_pkg::*;
#(
  parameter int PORT_BITS = PORT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [PORT_BITS-1:0] in_port,
  input  logic [3:0]           in_channel,
  input  logic [6:0]           in_controller,
  input  logic [6:0]           in_cc_value,
  input  logic [31:0]          in_time_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_has_event,
  output logic                 out_accepted,
  output logic [1:0]           out_kind,
  output logic [1:0]           out_port,
  output logic [3:0]           out_channel,
  output logic [13:0]          out_param,
  output logic [13:0]          out_value,
  output logic [31:0]          out_time,
  output logic                 out_last
);

  localparam int ADDR_W = PORT_BITS + 4;

  localparam logic [1:0] ST_CLR  = 2'd0;  // post-reset sweep
  localparam logic [1:0] ST_IDLE = 2'd1;  // ready for a request
  localparam logic [1:0] ST_EXEC = 2'd2;  // slot data back, modify and write

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r;
  req_t                 req_r;
  logic [PORT_BITS-1:0] port_r;
  logic [3:0]           chan_r;
  logic                 in_acc;
  logic                 commit;
  logic                 emit_free;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  slot_t                wr_data;
  slot_t                rd_data;
  slot_t                upd_nxt;
  slot_t                upd_snap;
  logic                 upd_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign commit   = (state_r == ST_EXEC) && emit_free;

  // request capture; slot address is {port, channel}
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= '{mode: in_mode, ctl: in_controller, val: in_cc_value, tstamp: in_time_req};
      port_r <= in_port;
      chan_r <= in_channel;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_addr_r == {ADDR_W{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: if (emit_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  // one write port shared by the clearing sweep and the write-back
  assign wr_en   = (state_r == ST_CLR) || commit;
  assign wr_addr = (state_r == ST_CLR) ? clr_addr_r : {port_r, chan_r};
  assign wr_data = (state_r == ST_CLR) ? '0 : upd_nxt;

  rnc14_slot_ram #(
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .rd_en  (in_acc),
    .rd_addr({in_port, in_channel}),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  rnc14_upd u_upd (
    .req (req_r),
    .cur (rd_data),
    .nxt (upd_nxt),
    .snap(upd_snap),
    .acc (upd_acc)
  );

  rnc14_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld           (commit),
    .ld_snap      (upd_snap),
    .ld_acc       (upd_acc),
    .ld_port      (2'(port_r)),
    .ld_channel   (chan_r),
    .free         (emit_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_has_event(out_has_event),
    .out_accepted (out_accepted),
    .out_kind     (out_kind),
    .out_port     (out_port),
    .out_channel  (out_channel),
    .out_param    (out_param),
    .out_value    (out_value),
    .out_time     (out_time),
    .out_last     (out_last)
  );

  a_acc_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EXEC))
    else $error("accepted request did not move to write-back");

  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && !emit_free) |=> ((state_r == ST_EXEC) && $stable(req_r)))
    else $error("request lost while waiting for result queue");

  a_wr_only_clr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == ST_CLR) || (state_r == ST_EXEC)))
    else $error("slot RAM written outside sweep or write-back");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the MIDI RPN/NRPN/14-bit controller assembler.
module tb_top
  import rnc14_pkg::*;
();

  localparam int NSLOT        = 16 << PORT_BITS_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_AT      = 150;  // requests accepted before the long output hold
  localparam int HOLD_CYCLES  = 300;

  // one input request as the bench sees it
  typedef struct packed {
    logic        mode;
    logic [1:0]  port;
    logic [3:0]  channel;
    logic [6:0]  controller;
    logic [6:0]  value;
    logic [31:0] stamp;
  } midi_req_t;

  // one output result
  typedef struct packed {
    logic        has_event;
    logic        accepted;
    kind_t       kind;
    logic [1:0]  port;
    logic [3:0]  channel;
    logic [13:0] param;
    logic [13:0] value;
    logic [31:0] stamp;
    logic        last;
  } cc_result_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        in_mode       = 1'b0;
  logic [1:0]  in_port       = '0;
  logic [3:0]  in_channel    = '0;
  logic [6:0]  in_controller = '0;
  logic [6:0]  in_cc_value   = '0;
  logic [31:0] in_time_req   = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        out_has_event;
  logic        out_accepted;
  logic [1:0]  out_kind;
  logic [1:0]  out_port;
  logic [3:0]  out_channel;
  logic [13:0] out_param;
  logic [13:0] out_value;
  logic [31:0] out_time;
  logic        out_last;

  midi_rpn_nrpn_cc14_assembler u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_port      (in_port),
    .in_channel   (in_channel),
    .in_controller(in_controller),
    .in_cc_value  (in_cc_value),
    .in_time_req  (in_time_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_has_event(out_has_event),
    .out_accepted (out_accepted),
    .out_kind     (out_kind),
    .out_port     (out_port),
    .out_channel  (out_channel),
    .out_param    (out_param),
    .out_value    (out_value),
    .out_time     (out_time),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Slot mirror: the bench's own copy of the per port/channel assembly state.
  // ---------------------------------------------------------------------------
  kind_t       tbl_kind  [NSLOT];
  part_t       tbl_ph    [NSLOT];  // parameter MSB (or 14-bit CC high controller)
  part_t       tbl_pl    [NSLOT];  // parameter LSB (or 14-bit CC low controller)
  part_t       tbl_dh    [NSLOT];  // data MSB
  part_t       tbl_dl    [NSLOT];  // data LSB
  logic [31:0] tbl_stamp [NSLOT];

  // events produced by the request being predicted
  ev_t         ev_list[$];
  logic [31:0] ev_stamp;
  logic [5:0]  ev_slot;

  midi_req_t   pending[$];           // requests not yet offered
  cc_result_t  expected_results[$];  // predicted results, oldest first
  midi_req_t   cur_req;              // request currently on the input port
  int          n_total    = 0;
  int          n_accepted = 0;
  int          n_errors   = 0;

  function automatic logic [13:0] merge_parts(part_t hi, part_t lo);
    if (lo.pres) return {(hi.pres ? hi.val : 7'd0), lo.val};
    if (hi.pres) return {7'd0, hi.val};
    return '0;
  endfunction

  function automatic logic any_held(int s);
    return tbl_ph[s].pres | tbl_pl[s].pres | tbl_dh[s].pres | tbl_dl[s].pres;
  endfunction

  function automatic logic slot_complete(int s);
    return (tbl_ph[s].pres | tbl_pl[s].pres) & tbl_dh[s].pres & tbl_dl[s].pres;
  endfunction

  function automatic void add_event(kind_t k, logic [13:0] p, logic [13:0] v);
    if (ev_list.size() < MAX_EV) ev_list.push_back('{kind: k, param: p, value: v});
  endfunction

  // Empty a slot: one assembled event if it is complete, else each held part
  // as a plain controller.
  function automatic void dump_slot(int s);
    kind_t k;
    logic  p_any;
    logic  d14;
    k = tbl_kind[s];
    if (k == K_NONE) return;
    ev_stamp = tbl_stamp[s];
    ev_slot  = s[5:0];
    p_any    = tbl_ph[s].pres | tbl_pl[s].pres;
    d14      = tbl_dh[s].pres & tbl_dl[s].pres;
    if (k == K_CC14) begin
      if (p_any && d14) begin
        add_event(K_CC14, {7'd0, tbl_ph[s].val}, merge_parts(tbl_dh[s], tbl_dl[s]));
      end else begin
        if (tbl_dh[s].pres) add_event(K_PLAIN, {7'd0, tbl_ph[s].val}, {7'd0, tbl_dh[s].val});
        if (tbl_dl[s].pres) add_event(K_PLAIN, {7'd0, tbl_pl[s].val}, {7'd0, tbl_dl[s].val});
      end
    end else if (p_any && d14) begin
      add_event(k, merge_parts(tbl_ph[s], tbl_pl[s]), merge_parts(tbl_dh[s], tbl_dl[s]));
    end else begin
      if (tbl_ph[s].pres)
        add_event(K_PLAIN, {7'd0, (k == K_RPN) ? CC_RPN_MSB : CC_NRPN_MSB},
                  {7'd0, tbl_ph[s].val});
      if (tbl_pl[s].pres)
        add_event(K_PLAIN, {7'd0, (k == K_RPN) ? CC_RPN_LSB : CC_NRPN_LSB},
                  {7'd0, tbl_pl[s].val});
      if (tbl_dh[s].pres) add_event(K_PLAIN, {7'd0, CC_DATA_MSB}, {7'd0, tbl_dh[s].val});
      if (tbl_dl[s].pres) add_event(K_PLAIN, {7'd0, CC_DATA_LSB}, {7'd0, tbl_dl[s].val});
    end
    tbl_kind[s]  = K_NONE;
    tbl_stamp[s] = '0;
    tbl_ph[s]    = '0;
    tbl_pl[s]    = '0;
    tbl_dh[s]    = '0;
    tbl_dl[s]    = '0;
  endfunction

  // first part of a sequence claims the slot and its timestamp
  function automatic void open_slot(int s, kind_t k, logic [31:0] t);
    if (tbl_kind[s] == K_NONE) begin
      tbl_kind[s]  = k;
      tbl_stamp[s] = t;
    end
  endfunction

  function automatic void take_param(int s, kind_t k, logic hi, logic [6:0] v, logic [31:0] t);
    part_t held;
    held = hi ? tbl_ph[s] : tbl_pl[s];
    if (held.pres || (any_held(s) && tbl_kind[s] != k)) dump_slot(s);
    open_slot(s, k, t);
    if (hi) tbl_ph[s] = '{pres: 1'b1, val: v};
    else    tbl_pl[s] = '{pres: 1'b1, val: v};
  endfunction

  // returns 1 when the data entry is absorbed
  function automatic logic take_data(int s, logic hi, logic [6:0] v);
    kind_t k;
    part_t held;
    k    = tbl_kind[s];
    held = hi ? tbl_dh[s] : tbl_dl[s];
    if (k == K_NONE) return 1'b0;
    if (held.pres || (k != K_RPN && k != K_NRPN)) begin
      dump_slot(s);
      return 1'b0;
    end
    if (hi) tbl_dh[s] = '{pres: 1'b1, val: v};
    else    tbl_dl[s] = '{pres: 1'b1, val: v};
    if (slot_complete(s)) dump_slot(s);
    return 1'b1;
  endfunction

  // 14-bit CC half: high controllers 1..31, low partners 33..63
  function automatic void take_cc14(int s, logic hi, logic [6:0] c, logic [6:0] v,
                                    logic [31:0] t);
    kind_t k;
    logic  brk;
    k = tbl_kind[s];
    if (hi)
      brk = tbl_ph[s].pres || tbl_dh[s].pres || (any_held(s) && k != K_CC14) ||
            (k == K_CC14 && tbl_pl[s].val != c + CC14_OFS);
    else
      brk = tbl_pl[s].pres || tbl_dl[s].pres || (any_held(s) && k != K_CC14) ||
            (k == K_CC14 && tbl_ph[s].val != c - CC14_OFS);
    if (brk) dump_slot(s);
    open_slot(s, K_CC14, t);
    if (hi) begin
      tbl_ph[s] = '{pres: 1'b1, val: c};
      tbl_dh[s] = '{pres: 1'b1, val: v};
    end else begin
      tbl_pl[s] = '{pres: 1'b1, val: c};
      tbl_dl[s] = '{pres: 1'b1, val: v};
    end
    if (slot_complete(s)) dump_slot(s);
  endfunction

  // Apply one accepted request to the mirror and queue the results it causes.
  function automatic void assemble_request(midi_req_t r);
    int         s;
    logic       acc;
    cc_result_t res;
    s   = int'({r.port, r.channel});
    acc = 1'b0;
    ev_list.delete();
    if (r.mode) begin
      dump_slot(s);
    end else if (r.controller == CC_RPN_MSB) begin
      take_param(s, K_RPN, 1'b1, r.value, r.stamp);
      acc = 1'b1;
    end else if (r.controller == CC_RPN_LSB) begin
      take_param(s, K_RPN, 1'b0, r.value, r.stamp);
      acc = 1'b1;
    end else if (r.controller == CC_NRPN_MSB) begin
      take_param(s, K_NRPN, 1'b1, r.value, r.stamp);
      acc = 1'b1;
    end else if (r.controller == CC_NRPN_LSB) begin
      take_param(s, K_NRPN, 1'b0, r.value, r.stamp);
      acc = 1'b1;
    end else if (r.controller == CC_DATA_MSB) begin
      acc = take_data(s, 1'b1, r.value);
    end else if (r.controller == CC_DATA_LSB) begin
      acc = take_data(s, 1'b0, r.value);
    end else if (r.controller > 7'd0 && r.controller < CC14_OFS) begin
      take_cc14(s, 1'b1, r.controller, r.value, r.stamp);
      acc = 1'b1;
    end else if (r.controller > CC14_OFS && r.controller < CC14_LSB_END) begin
      take_cc14(s, 1'b0, r.controller, r.value, r.stamp);
      acc = 1'b1;
    end
    // nothing emitted: a single empty result closes the request
    if (ev_list.size() == 0) begin
      res          = '0;
      res.accepted = acc;
      res.last     = 1'b1;
      expected_results.push_back(res);
    end
    for (int i = 0; i < ev_list.size(); i++) begin
      res.has_event = 1'b1;
      res.accepted  = acc;
      res.kind      = ev_list[i].kind;
      res.port      = ev_slot[5:4];
      res.channel   = ev_slot[3:0];
      res.param     = ev_list[i].param;
      res.value     = ev_list[i].value;
      res.stamp     = ev_stamp;
      res.last      = (i == ev_list.size() - 1);
      expected_results.push_back(res);
    end
  endfunction

  function automatic void add_req(logic m, logic [1:0] p, logic [3:0] ch, logic [6:0] c,
                                  logic [6:0] v, logic [31:0] t);
    pending.push_back('{mode: m, port: p, channel: ch, controller: c, value: v, stamp: t});
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between. A request
  // stays on the port untouched until accepted; prediction happens at accept.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        tbl_kind[i]  = K_NONE;
        tbl_stamp[i] = '0;
        tbl_ph[i]    = '0;
        tbl_pl[i]    = '0;
        tbl_dh[i]    = '0;
        tbl_dl[i]    = '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        assemble_request(cur_req);
        n_accepted++;
      end
      // port is free unless a request is sitting there stalled
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req        = pending.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= cur_req.mode;
          in_port       <= cur_req.port;
          in_channel    <= cur_req.channel;
          in_controller <= cur_req.controller;
          in_cc_value   <= cur_req.value;
          in_time_req   <= cur_req.stamp;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall pattern: phases of no stall, random stall, heavy stall and
  // alternate-cycle stall; once, a long hold so the block backs up to its input.
  // ---------------------------------------------------------------------------
  int   stall_phase = 0;
  int   phase_left  = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;
  logic [1:0] stall_tick = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 2'd1;
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_phase = $urandom_range(0, 3);
          phase_left  = $urandom_range(16, 64);
        end else begin
          phase_left--;
        end
        case (stall_phase)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (stall_tick != 2'd0);
          default: out_stall <= stall_tick[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  cc_result_t got;
  cc_result_t want;

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{has_event: out_has_event, accepted: out_accepted, kind: out_kind,
              port: out_port, channel: out_channel, param: out_param,
              value: out_value, stamp: out_time, last: out_last};
      if (expected_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_results.pop_front();
        check_field("has_event", 32'(want.has_event), 32'(got.has_event));
        check_field("accepted",  32'(want.accepted),  32'(got.accepted));
        check_field("kind",      32'(want.kind),      32'(got.kind));
        check_field("port",      32'(want.port),      32'(got.port));
        check_field("channel",   32'(want.channel),   32'(got.channel));
        check_field("param",     32'(want.param),     32'(got.param));
        check_field("value",     32'(want.value),     32'(got.value));
        check_field("time",      want.stamp,          got.stamp);
        check_field("last",      32'(want.last),      32'(got.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0] seq_ctl[$];
    logic [6:0] swap_c;
    logic [6:0] c;
    logic [1:0] p;
    logic [3:0] ch;
    logic       nrpn;
    int         n_directed;
    int         pick;
    int         j;

    // directed: pass-through extremes, flush of an empty slot, orphan data
    add_req(1'b0, 2'd0, 4'd0,  7'h00, 7'h00, 32'h0);
    add_req(1'b0, 2'd3, 4'd15, 7'h7f, 7'h7f, 32'hffff_ffff);
    add_req(1'b1, 2'd1, 4'd5,  7'h00, 7'h00, $urandom());
    add_req(1'b0, 2'd1, 4'd5,  CC_DATA_MSB, 7'h11, $urandom());
    // complete RPN with extreme values and timestamp
    add_req(1'b0, 2'd3, 4'd15, CC_RPN_MSB,  7'h7f, 32'hffff_ffff);
    add_req(1'b0, 2'd3, 4'd15, CC_RPN_LSB,  7'h00, 32'h0);
    add_req(1'b0, 2'd3, 4'd15, CC_DATA_MSB, 7'h7f, $urandom());
    add_req(1'b0, 2'd3, 4'd15, CC_DATA_LSB, 7'h7f, $urandom());
    // partial NRPN emptied by a flush: three plain controllers
    add_req(1'b0, 2'd0, 4'd0,  CC_NRPN_MSB, 7'h05, 32'h0);
    add_req(1'b0, 2'd0, 4'd0,  CC_NRPN_LSB, 7'h06, $urandom());
    add_req(1'b0, 2'd0, 4'd0,  CC_DATA_MSB, 7'h07, $urandom());
    add_req(1'b1, 2'd0, 4'd0,  7'h7f, 7'h7f, 32'hffff_ffff);
    // 14-bit CC pairs, high first and low first
    add_req(1'b0, 2'd3, 4'd15, 7'h1f, 7'h7f, 32'hffff_ffff);
    add_req(1'b0, 2'd3, 4'd15, 7'h3f, 7'h7f, $urandom());
    add_req(1'b0, 2'd2, 4'd9,  7'h21, 7'h01, $urandom());
    add_req(1'b0, 2'd2, 4'd9,  7'h01, 7'h02, $urandom());
    // mismatched partner breaks the pair, then data entry on a 14-bit slot
    add_req(1'b0, 2'd1, 4'd1,  7'h07, 7'h03, $urandom());
    add_req(1'b0, 2'd1, 4'd1,  7'h28, 7'h04, $urandom());
    add_req(1'b0, 2'd1, 4'd1,  CC_DATA_LSB, 7'h55, $urandom());
    // RPN part interrupted by an NRPN part
    add_req(1'b0, 2'd2, 4'd2,  CC_RPN_MSB,  7'h2a, $urandom());
    add_req(1'b0, 2'd2, 4'd2,  CC_NRPN_LSB, 7'h15, $urandom());
    // data part repeated while already held
    add_req(1'b0, 2'd2, 4'd3,  CC_RPN_LSB,  7'h40, $urandom());
    add_req(1'b0, 2'd2, 4'd3,  CC_DATA_MSB, 7'h3c, $urandom());
    add_req(1'b0, 2'd2, 4'd3,  CC_DATA_MSB, 7'h43, $urandom());
    // controller 0x20 itself is plain
    add_req(1'b0, 2'd2, 4'd2,  CC14_OFS,    7'h66, $urandom());
    n_directed = pending.size();

    // random: mostly well-formed sequences on a hot subset of slots or anywhere
    while (pending.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        p  = 2'($urandom_range(0, 1));
        ch = 4'($urandom_range(0, 3));
      end else begin
        p  = 2'($urandom_range(0, 3));
        ch = 4'($urandom_range(0, 15));
      end
      pick = $urandom_range(0, 9);
      seq_ctl.delete();
      if (pick <= 3) begin
        // RPN or NRPN, occasionally missing parts or out of order
        nrpn = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) != 0) seq_ctl.push_back(nrpn ? CC_NRPN_MSB : CC_RPN_MSB);
        if ($urandom_range(0, 7) != 0 || seq_ctl.size() == 0)
          seq_ctl.push_back(nrpn ? CC_NRPN_LSB : CC_RPN_LSB);
        if (seq_ctl.size() == 2 && $urandom_range(0, 1) == 1) begin
          swap_c     = seq_ctl[0];
          seq_ctl[0] = seq_ctl[1];
          seq_ctl[1] = swap_c;
        end
        if ($urandom_range(0, 7) != 0) seq_ctl.push_back(CC_DATA_MSB);
        if ($urandom_range(0, 7) != 0) seq_ctl.push_back(CC_DATA_LSB);
        if ($urandom_range(0, 3) == 0) begin
          j                        = seq_ctl.size() - 1;
          swap_c                   = seq_ctl[j];
          seq_ctl[j]               = seq_ctl[$urandom_range(0, j)];
          seq_ctl[$urandom_range(0, j)] = swap_c;
        end
      end else if (pick <= 6) begin
        // 14-bit pair, sometimes one half only or a wrong partner
        c = 7'($urandom_range(1, 31));
        seq_ctl.push_back(c);
        j = $urandom_range(0, 7);
        if (j == 0)      seq_ctl.push_back(7'($urandom_range(33, 63)));
        else if (j != 1) seq_ctl.push_back(c + CC14_OFS);
        if ($urandom_range(0, 1) == 1 && seq_ctl.size() == 2) begin
          swap_c     = seq_ctl[0];
          seq_ctl[0] = seq_ctl[1];
          seq_ctl[1] = swap_c;
        end
      end else if (pick == 7) begin
        seq_ctl.push_back(7'($urandom_range(0, 127)));
      end else if (pick == 8) begin
        add_req(1'b1, p, ch, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                $urandom());
      end else begin
        // stray single part of some sequence
        case ($urandom_range(0, 3))
          0: seq_ctl.push_back(CC_DATA_MSB);
          1: seq_ctl.push_back(CC_DATA_LSB);
          2: seq_ctl.push_back($urandom_range(0, 1) ? CC_RPN_MSB : CC_NRPN_LSB);
          default: seq_ctl.push_back(7'($urandom_range(1, 63)));
        endcase
      end
      foreach (seq_ctl[k])
        add_req(1'b0, p, ch, seq_ctl[k], 7'($urandom_range(0, 127)), $urandom());
      if (pick <= 3 && $urandom_range(0, 3) == 0)
        add_req(1'b1, p, ch, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                $urandom());
    end
    n_total = pending.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // let any stray extra result show up
    repeat (30) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
